// File: sv/breakpoint_curve_cubic_evaluator_top_defines.svh
// Assertion macros for the breakpoint curve evaluator.
`ifndef BREAKPOINT_CURVE_CUBIC_EVALUATOR_TOP_DEFINES_SVH
`define BREAKPOINT_CURVE_CUBIC_EVALUATOR_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BCE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define BCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: sv/bce_pkg.sv
// Shared types and constants for the breakpoint curve evaluator.
`default_nettype none
package bce_pkg;
    localparam int MAX_POINTS_DEF = 16;
    localparam int COUNT_W        = 5;
    localparam int IDX_W          = 4;
    localparam int DATA_W         = 16;
    localparam int T_W            = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_FETCH,
        ST_COEF,
        ST_DIV,
        ST_HORNER,
        ST_FINISH,
        ST_OUT
    } t_state;

    // divider handshake
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage
`default_nettype wire

// File: sv/bce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/bce_div.sv
// Restoring divider: quotient of num*65536/den, one bit per cycle, clamped to 16 bits.
`default_nettype none
module bce_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [bce_pkg::DATA_W:0] i_num,
    input  wire logic [bce_pkg::DATA_W:0] i_den,
    output bce_pkg::t_div_ctl             o_ctl,
    output logic [bce_pkg::T_W-1:0]       o_quot
);
    localparam int QW = bce_pkg::T_W + 1;
    logic [bce_pkg::DATA_W+1:0] r_rem;
    logic [QW-1:0]              r_quot;
    logic [4:0]                 r_cnt;
    logic                       r_busy, r_done;
    logic [bce_pkg::DATA_W+1:0] w_sh, w_sub;

    // numerator < denominator*2, so 17 quotient bits cover it
    assign w_sh  = {r_rem[bce_pkg::DATA_W:0], 1'b0};
    assign w_sub = w_sh - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(QW);
                r_rem  <= {1'b0, i_num};
                r_quot <= '0;
            end else if (r_busy) begin
                // rem starts as num; subtract den first at 2^16 scale
                if (r_cnt == 5'(QW)) begin
                    if ({1'b0, r_rem[bce_pkg::DATA_W:0]} >= {1'b0, i_den}) begin
                        r_rem  <= r_rem - {1'b0, i_den};
                        r_quot <= QW'(1);
                    end
                end else if (!w_sub[bce_pkg::DATA_W+1]) begin
                    r_rem  <= w_sub;
                    r_quot <= {r_quot[QW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_sh;
                    r_quot <= {r_quot[QW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_quot = r_quot[QW-1] ? {bce_pkg::T_W{1'b1}} : r_quot[bce_pkg::T_W-1:0];
endmodule
`default_nettype wire

// File: sv/bce_core.sv
// Sequencer for segment search and Horner evaluation, with one multiply-accumulate reused for each Horner step.
`default_nettype none
module bce_core #(
    parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [bce_pkg::COUNT_W-1:0]    i_point_count,
    input  wire logic                           i_start,
    input  wire logic [bce_pkg::DATA_W-1:0]     i_position,
    output logic [$clog2(MAX_POINTS)-1:0]       o_raddr,
    input  wire logic [bce_pkg::DATA_W-1:0]     i_x_rdata,
    input  wire logic [bce_pkg::DATA_W-1:0]     i_y_rdata,
    output logic                                o_busy,
    output logic                                o_done,
    output logic signed [bce_pkg::DATA_W-1:0]   o_level
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int HW = 22;

    bce_pkg::t_state r_state, n_state;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_i;           // running index
    logic [1:0]    r_sub;         // read phase
    logic [AW-1:0] r_idx;
    logic          r_found;
    logic [bce_pkg::DATA_W-1:0] r_pos, r_x0, r_xa, r_xb, r_xprev;
    logic signed [bce_pkg::DATA_W-1:0] r_y [4];
    logic signed [bce_pkg::DATA_W-1:0] r_ylast, r_yfirst;
    logic signed [HW-1:0] r_c [4];
    logic signed [HW-1:0] r_h;
    logic [1:0]    r_hstep;
    logic [bce_pkg::T_W-1:0] r_t;
    logic signed [bce_pkg::DATA_W-1:0] r_level;
    logic          r_div_start;
    bce_pkg::t_div_ctl w_div;
    logic [bce_pkg::T_W-1:0] w_quot;
    logic [bce_pkg::DATA_W:0] w_num, w_den;
    logic          w_t_zero;
    logic signed [HW+bce_pkg::T_W:0] w_prod;
    logic signed [HW-1:0] w_rnd;
    logic [NW-1:0] w_ai;

    assign w_num = {1'b0, r_pos} - {1'b0, r_xa};
    assign w_den = {1'b0, r_xb} - {1'b0, r_xa};
    // no positive ratio (flat segment or unsorted table): t stays zero
    assign w_t_zero = w_num[bce_pkg::DATA_W] || (w_num == '0) ||
                      w_den[bce_pkg::DATA_W] || (w_den == '0);

    bce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_ctl   (w_div),
        .o_quot  (w_quot)
    );

    // the one multiplier: h * t, rounded to Q16
    assign w_prod = r_h * $signed({1'b0, r_t});
    assign w_rnd  = HW'((w_prod + (HW+bce_pkg::T_W+1)'(32768)) >>> 16);

    // read address for fetch phase: idx-1, idx, idx+1, idx+2 clamped
    always_comb begin
        w_ai = NW'(r_idx);
        unique case (r_sub)
            2'd0: w_ai = (r_idx == '0) ? NW'(r_idx) : NW'(r_idx) - NW'(1);
            2'd1: w_ai = NW'(r_idx);
            2'd2: w_ai = NW'(r_idx) + NW'(1);
            default: w_ai = (NW'(r_idx) + NW'(2) < r_n) ? NW'(r_idx) + NW'(2)
                                                        : NW'(r_idx) + NW'(1);
        endcase
    end

    always_comb begin
        o_raddr = AW'(r_i);
        if (r_state == bce_pkg::ST_FETCH) begin
            o_raddr = AW'(w_ai);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: search reads one entry a cycle (its data arrives in the next cycle)
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bce_pkg::ST_IDLE:   if (i_start) n_state = bce_pkg::ST_SEARCH;
            bce_pkg::ST_SEARCH: if (r_i == r_n) n_state = bce_pkg::ST_CHECK;
            bce_pkg::ST_CHECK:  n_state = (r_n < NW'(2) || r_pos < r_x0 || r_pos > r_xprev)
                                          ? bce_pkg::ST_FINISH : bce_pkg::ST_FETCH;
            bce_pkg::ST_FETCH:  if (r_sub == 2'd3 && r_found) n_state = bce_pkg::ST_COEF;
            bce_pkg::ST_COEF:   n_state = bce_pkg::ST_DIV;
            bce_pkg::ST_DIV:    if (w_div.done) n_state = bce_pkg::ST_HORNER;
            bce_pkg::ST_HORNER: if (r_hstep == 2'd2) n_state = bce_pkg::ST_FINISH;
            bce_pkg::ST_FINISH: n_state = bce_pkg::ST_OUT;
            bce_pkg::ST_OUT:    n_state = bce_pkg::ST_IDLE;
            default:            n_state = bce_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                bce_pkg::ST_IDLE: begin
                    r_pos   <= i_position;
                    r_n     <= (32'(i_point_count) > 32'(MAX_POINTS))
                               ? NW'(MAX_POINTS) : NW'(i_point_count);
                    r_i     <= '0;
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_sub   <= '0;
                    r_hstep <= '0;
                end
                bce_pkg::ST_SEARCH: begin
                    // data from address r_i-1 arrives now
                    if (r_i != '0) begin
                        if (r_i == NW'(1)) begin
                            r_x0     <= i_x_rdata;
                            r_yfirst <= $signed(i_y_rdata);
                        end else if (!r_found && r_pos >= r_xprev && r_pos <= i_x_rdata) begin
                            r_found <= 1'b1;
                            r_idx   <= AW'(r_i - NW'(2));
                        end
                        r_xprev <= i_x_rdata;
                        r_ylast <= $signed(i_y_rdata);
                    end
                    if (r_i != r_n) r_i <= r_i + NW'(1);
                end
                bce_pkg::ST_CHECK: begin
                    r_found <= 1'b0;
                    r_sub   <= '0;
                end
                bce_pkg::ST_FETCH: begin
                    // r_found reused as "data pending" flag for staggered reads
                    if (r_found) r_y[r_sub] <= $signed(i_y_rdata);
                    if (r_sub == 2'd1 && r_found) r_xa <= i_x_rdata;
                    if (r_sub == 2'd2 && r_found) r_xb <= i_x_rdata;
                    if (!r_found) begin
                        r_found <= 1'b1;
                    end else begin
                        r_found <= 1'b0;
                        r_sub   <= r_sub + 2'd1;
                    end
                end
                bce_pkg::ST_COEF: begin
                    r_c[0] <= HW'(r_y[1]) <<< 1;
                    r_c[1] <= HW'(r_y[2]) - HW'(r_y[0]);
                    r_c[2] <= (HW'(r_y[0]) <<< 1) - HW'(r_y[1]) * HW'(5)
                              + (HW'(r_y[2]) <<< 2) - HW'(r_y[3]);
                    r_c[3] <= -HW'(r_y[0]) + HW'(r_y[1]) * HW'(3)
                              - HW'(r_y[2]) * HW'(3) + HW'(r_y[3]);
                    r_div_start <= 1'b1;
                    r_t <= '0;
                end
                bce_pkg::ST_DIV: begin
                    r_h <= r_c[3];
                    if (w_div.done) r_t <= w_t_zero ? '0 : w_quot;
                end
                bce_pkg::ST_HORNER: begin
                    r_h     <= w_rnd + r_c[2'd2 - r_hstep];
                    r_hstep <= r_hstep + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // final rounding/saturation, a clamped end value, or zero for an empty table
    logic signed [HW-1:0] w_r;
    assign w_r = (r_h + HW'(1)) >>> 1;
    always_ff @(posedge i_clk) begin
        if (r_state == bce_pkg::ST_FINISH) begin
            if (r_n == '0) r_level <= '0;
            else if (r_n == NW'(1) || r_pos < r_x0) r_level <= r_yfirst;
            else if (r_pos > r_xprev) r_level <= r_ylast;
            else if (w_r > HW'(32767)) r_level <= 16'sh7FFF;
            else if (w_r < -HW'(32768)) r_level <= -16'sh8000;
            else r_level <= w_r[bce_pkg::DATA_W-1:0];
        end
    end

    assign o_busy  = (r_state != bce_pkg::ST_IDLE);
    assign o_done  = (r_state == bce_pkg::ST_OUT);
    assign o_level = r_level;
endmodule
`default_nettype wire

// File: sv/breakpoint_curve_cubic_evaluator_top.sv
// Top level of the breakpoint curve evaluator: stream ports, tables, core.
// An evaluate word runs a sequencer around one divider and one 22x17 multiplier: a search pass
// reads the tables once, the four neighbours are fetched, the divider runs, then Horner steps
// follow, with no new word taken meanwhile; the result then waits in an output register.
// Tables are undefined until written; read only entries that were loaded.
`default_nettype none
module breakpoint_curve_cubic_evaluator_top #(
    parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,          // point_count
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,         // point_index[3:0] point_x[19:4] point_y[35:20] position[51:36]
    input  wire logic        s_axis_tuser,         // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata          // level
);
    localparam int AW = $clog2(MAX_POINTS);
    logic [bce_pkg::COUNT_W-1:0] r_point_count;
    logic r_out_valid;
    logic w_busy, w_done, w_acc, w_we;
    logic [AW-1:0] w_raddr;
    logic [bce_pkg::DATA_W-1:0] w_x, w_y;
    logic signed [bce_pkg::DATA_W-1:0] w_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) r_point_count <= i_cfg_wdata;
            if (w_done) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = !w_busy && !r_out_valid;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_we  = w_acc && !s_axis_tuser &&
                   ({28'd0, s_axis_tdata[3:0]} < 32'(MAX_POINTS));

    bce_ram #(.WIDTH(bce_pkg::DATA_W), .DEPTH(MAX_POINTS)) u_xram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(AW'(s_axis_tdata[3:0])),
        .i_wdata(s_axis_tdata[19:4]), .i_raddr(w_raddr), .o_rdata(w_x));
    bce_ram #(.WIDTH(bce_pkg::DATA_W), .DEPTH(MAX_POINTS)) u_yram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(AW'(s_axis_tdata[3:0])),
        .i_wdata(s_axis_tdata[35:20]), .i_raddr(w_raddr), .o_rdata(w_y));

    bce_core #(.MAX_POINTS(MAX_POINTS)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_point_count(r_point_count),
        .i_start(w_acc && s_axis_tuser), .i_position(s_axis_tdata[51:36]),
        .o_raddr(w_raddr), .i_x_rdata(w_x), .i_y_rdata(w_y),
        .o_busy(w_busy), .o_done(w_done), .o_level(w_level));

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = w_level;
endmodule
`default_nettype wire

// File: sv/bce_checker.sv
// Port-level checker for the breakpoint curve evaluator, bound to the top level.
`default_nettype none
`include "breakpoint_curve_cubic_evaluator_top_defines.svh"
module bce_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);
    `BCE_ASSERT_IMPL(a_no_accept_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
    `BCE_ASSERT_NEXT(a_eval_blocks, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready, "ready during evaluation")
    `BCE_ASSERT_NEXT(a_write_no_out, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tuser, !m_axis_tvalid, "write produced a result")
    `BCE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule
bind breakpoint_curve_cubic_evaluator_top bce_checker u_bce_checker (.*);
`default_nettype wire

// File: sim/bce_tb_pkg.sv
// Opcode and table depth shared by the evaluator testbench files.
`timescale 1ns / 100ps
package bce_tb_pkg;
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

    localparam int TABLE_DEPTH = 16;
endpackage

// File: sim/bce_curve_checker.sv
// Checker for the breakpoint curve evaluator: tracks table and count, predicts each level.
`timescale 1ns / 100ps
module bce_curve_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [55:0] i_s_tdata,   // index[3:0] x[19:4] y[35:20] position[51:36]
    input  wire logic        i_s_tuser,   // op
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,   // level
    output int               o_pending,
    output int               o_errors
);
    logic        [15:0] phase_copy [bce_tb_pkg::TABLE_DEPTH];
    logic signed [15:0] level_copy [bce_tb_pkg::TABLE_DEPTH];
    logic        [4:0]  count_copy;
    logic signed [15:0] level_queue [$];

    // floor(v / 2^16) after adding half
    function automatic longint round_q16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic logic signed [15:0] curve_level(logic [15:0] pos);
        int     n, seg, i0, i3;
        longint y0, y1, y2, y3, c0, c1, c2, c3, num, den, t, h;
        n = (count_copy > bce_tb_pkg::TABLE_DEPTH) ? bce_tb_pkg::TABLE_DEPTH
                                                   : int'(count_copy);
        if (n == 0)
            return 16'sd0;
        if (n == 1)
            return level_copy[0];
        seg = 0;
        for (int i = 0; i + 1 < n; i++) begin
            if (pos >= phase_copy[i] && pos <= phase_copy[i + 1]) begin
                seg = i;
                break;
            end
        end
        if (pos < phase_copy[0])
            return level_copy[0];
        if (pos > phase_copy[n - 1])
            return level_copy[n - 1];
        // neighbours clamp at the table edges
        i0 = (seg > 0) ? seg - 1 : seg;
        i3 = (seg + 2 < n) ? seg + 2 : seg + 1;
        y0 = longint'(level_copy[i0]);
        y1 = longint'(level_copy[seg]);
        y2 = longint'(level_copy[seg + 1]);
        y3 = longint'(level_copy[i3]);
        num = longint'(pos) - longint'(phase_copy[seg]);
        den = longint'(phase_copy[seg + 1]) - longint'(phase_copy[seg]);
        if (num <= 0 || den <= 0) begin
            t = 0;
        end else begin
            t = (num * 65536) / den;
            if (t > 65535)
                t = 65535;
        end
        c0 = 2 * y1;
        c1 = y2 - y0;
        c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
        c3 = -y0 + 3 * y1 - 3 * y2 + y3;
        h = c3;
        h = round_q16(h * t) + c2;
        h = round_q16(h * t) + c1;
        h = round_q16(h * t) + c0;
        h = (h + 1) >>> 1;
        if (h > 32767)
            h = 32767;
        if (h < -32768)
            h = -32768;
        return h[15:0];
    endfunction

    initial begin
        o_errors  = 0;
        o_pending = 0;
        count_copy = '0;
    end

    always @(posedge i_clk) begin
        logic signed [15:0] want;
        if (!i_rst_n) begin
            count_copy <= '0;
        end else begin
            if (i_cfg_we)
                count_copy <= i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                if (bce_tb_pkg::t_op'(i_s_tuser) == bce_tb_pkg::OP_WRITE) begin
                    phase_copy[i_s_tdata[3:0]] = i_s_tdata[19:4];
                    level_copy[i_s_tdata[3:0]] = i_s_tdata[35:20];
                end else begin
                    level_queue = {level_queue, curve_level(i_s_tdata[51:36])};
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (level_queue.size() == 0) begin
                    $display("%0t: unexpected level word, expected none, got %0d",
                             $time, $signed(i_m_tdata));
                    o_errors <= o_errors + 1;
                end else begin
                    want = level_queue.pop_front();
                    if (want !== $signed(i_m_tdata)) begin
                        $display("%0t: level mismatch, expected %0d, got %0d",
                                 $time, want, $signed(i_m_tdata));
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= level_queue.size();
        end
    end
endmodule

// File: sim/tb_breakpoint_curve_cubic_evaluator_top.sv
// Testbench top for the breakpoint curve evaluator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_breakpoint_curve_cubic_evaluator_top;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    int          pending;
    int          errors;

    int          burst_left = 0;
    logic        hold_req = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_cnt = 0;
    int          stall_mode = 0;
    int          mode_cnt = 0;
    int          eval_lo, eval_hi;

    always #6 i_clk = ~i_clk;

    breakpoint_curve_cubic_evaluator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bce_curve_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // receiver: stall pattern switches whenever its mode counter runs out; a hold request forces a long stall
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt  <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ~m_axis_tready;
            endcase
        end
        if (mode_cnt == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_cnt   <= 50;
        end else begin
            mode_cnt <= mode_cnt - 1;
        end
    end

    task automatic send_word(bce_tb_pkg::t_op op, logic [3:0] idx, logic [15:0] px,
                             logic [15:0] py, logic [15:0] pos);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, pos, py, px, idx};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic write_point(int idx, int px, int py);
        send_word(bce_tb_pkg::OP_WRITE, idx[3:0], px[15:0], py[15:0], 16'($urandom));
    endtask

    task automatic eval_at(int pos);
        send_word(bce_tb_pkg::OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom),
                  pos[15:0]);
    endtask

    // quiet the input and wait for every level word, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_count(int value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[4:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // loads all entries; mostly ascending, sometimes shuffled noise
    task automatic load_table(int style);
        int x, step;
        x = (style == 2) ? 0 : $urandom_range(0, 6000);
        eval_lo = x;
        for (int k = 0; k < bce_tb_pkg::TABLE_DEPTH; k++) begin
            if (style == 1) begin
                x = $urandom_range(0, 32768);
            end else begin
                step = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4096);
                x = (x + step > 32768) ? 32768 : x + step;
            end
            write_point(k, x, ($urandom_range(0, 4) == 0) ?
                        (($urandom_range(0, 1) == 1) ? 32767 : -32768) :
                        $signed(16'($urandom)));
        end
        eval_hi = x;
    endtask

    initial begin
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, then edges, plateaus, saturation and unsorted entries
        eval_at(0);
        eval_at(32768);
        for (int k = 0; k < bce_tb_pkg::TABLE_DEPTH; k++)
            write_point(k, (k < 2) ? 0 : ((k == 15) ? 32768 : k * 2048),
                        (k % 2 == 0) ? 32767 : -32768);
        set_count(1);
        eval_at(12345);
        set_count(16);
        eval_at(0);
        eval_at(32768);
        eval_at(3000);
        eval_at(17000);
        eval_at(31000);
        set_count(31);
        eval_at(9000);
        write_point(0, 1000, -5);
        eval_at(10);
        write_point(5, 500, 1234);
        eval_at(11000);
        set_count(2);
        eval_at(32768);
        eval_at(1500);

        for (int phase = 0; phase < 24; phase++) begin
            case ($urandom_range(0, 5))
                0: n = 0;
                1: n = 1;
                2: n = 16;
                3: n = $urandom_range(17, 31);
                default: n = $urandom_range(2, 15);
            endcase
            set_count(n);
            load_table(($urandom_range(0, 5) == 0) ? 1 : $urandom_range(0, 2) == 0 ? 2 : 0);
            if (phase == 5) begin
                hold_req <= ~hold_req;
                burst_left = 40;
            end
            for (int e = 0; e < 26; e++) begin
                if ($urandom_range(0, 4) == 0)
                    eval_at($urandom_range(0, 32768));
                else if (eval_hi > eval_lo)
                    eval_at($urandom_range(eval_lo, eval_hi));
                else
                    eval_at(eval_lo);
            end
        end
        drain();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end
endmodule

// File: breakpoint_curve_cubic_evaluator_top.f
+incdir+sv
sv/bce_pkg.sv
sv/bce_ram.sv
sv/bce_div.sv
sv/bce_core.sv
sv/breakpoint_curve_cubic_evaluator_top.sv
sv/bce_checker.sv
sim/bce_tb_pkg.sv
sim/bce_curve_checker.sv
sim/tb_breakpoint_curve_cubic_evaluator_top.sv
